[rtl/kwm_pkg.sv]
// Shared constants, types and handshake structs for the k-way record merge.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package kwm_pkg;

    // Number of source streams and stored payload width.
    localparam int NUM_WAYS     = 8;
    localparam int PAYLOAD_BITS = 64;

    // Only streams 0 to 7 can be addressed by the 3-bit stream index.
    localparam int EFF_WAYS = (NUM_WAYS < 8) ? NUM_WAYS : 8;
    localparam int WAY_W    = $clog2(EFF_WAYS);

    // Fixed field widths of the items.
    localparam int STREAM_W  = 3;
    localparam int KEY_W     = 32;
    localparam int PAYLOAD_W = 64;
    localparam int MASK_W    = 8;

    // Byte-aligned stream widths.
    localparam int TDATA_W     = ((KEY_W + PAYLOAD_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = STREAM_W;
    localparam int M_TUSER_W   = STREAM_W + 2;

    // One input item causes at most this many emitted records.
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEL  = 3'b010,
        ST_REJ  = 3'b100
    } kwm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_in;      // an input item is accepted this cycle
        logic emit;         // load the selected head into the output register
        logic load_reject;  // load a reject result into the output register
    } kwm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic accept_ok;    // the offered item may be stored in its head slot
        logic emit_ready;   // every participating stream holds a head
        logic out_free;     // the output register can take a result
        logic last_emit;    // the pending emission ends the cascade
    } kwm_status_t;

endpackage

[rtl/kwm_ctrl.sv]
// Controller state machine for the k-way record merge.
// Depends on kwm_pkg for the state enum and command/status structs.
`timescale 1ns / 1ps

module kwm_ctrl
    import kwm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  kwm_status_t status,
    output kwm_cmd_t    cmd
);

    kwm_state_t state_reg;
    kwm_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_in = 1'b1;
                    state_next  = status.accept_ok ? ST_SEL : ST_REJ;
                end
            end
            ST_SEL: begin
                if (!status.emit_ready) begin
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_emit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REJ: begin
                if (status.out_free) begin
                    cmd.load_reject = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A reject result is always the only result of its item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_reject |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after a reject");

    // The state register always holds exactly one state bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    // Items are only taken while the controller is idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_in |-> state_reg == ST_IDLE)
        else $error("item taken outside idle");

endmodule

[rtl/kwm_datapath.sv]
// Datapath of the k-way record merge: head slots, stream flags, minimum
// select over the heads, emission counter and output register.
// Depends on kwm_pkg; driven by kwm_ctrl through kwm_cmd_t.
`timescale 1ns / 1ps

module kwm_datapath
    import kwm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [MASK_W-1:0]    cfg_data,
    input  logic                 cfg_wr,
    input  logic [TDATA_W-1:0]   s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast,
    input  kwm_cmd_t             cmd,
    output kwm_status_t          status
);

    // Configuration and per-stream control state.
    logic [MASK_W-1:0]   active_mask_reg;
    logic [EFF_WAYS-1:0] head_full_reg;
    logic [EFF_WAYS-1:0] head_final_reg;
    logic [EFF_WAYS-1:0] finished_reg;
    logic [CNT_W-1:0]    emit_cnt_reg;
    logic [STREAM_W-1:0] in_stream_reg;

    // Head records.
    logic signed [KEY_W-1:0]        head_key_reg [EFF_WAYS];
    logic        [PAYLOAD_BITS-1:0] head_pay_reg [EFF_WAYS];

    // Output register.
    logic                    m_valid_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [PAYLOAD_W-1:0]    out_pay_reg;
    logic [STREAM_W-1:0]     out_src_reg;
    logic                    out_reject_reg;
    logic                    out_done_reg;
    logic                    out_last_reg;

    // Incoming item fields.
    logic signed [KEY_W-1:0] in_key;
    logic [PAYLOAD_W-1:0]    in_pay;
    logic [WAY_W-1:0]        in_way;
    logic                    in_range;

    logic [EFF_WAYS-1:0]     part;
    logic [EFF_WAYS-1:0]     part_after;
    logic                    any_part;
    logic                    all_full;
    logic [WAY_W-1:0]        sel;
    logic signed [KEY_W-1:0] min_key;
    logic                    sel_final;
    logic                    left;

    assign in_key   = s_tdata[KEY_W-1:0];
    assign in_pay   = s_tdata[KEY_W+PAYLOAD_W-1:KEY_W];
    assign in_way   = s_tuser[WAY_W-1:0];
    assign in_range = (32'(s_tuser) < EFF_WAYS);

    // A stream takes part while it is active and not yet finished.
    assign part = active_mask_reg[EFF_WAYS-1:0] & ~finished_reg;

    // Pick the least key. The search starts from the highest participating
    // stream and moves only on a strictly smaller key, which gives the
    // highest stream the tie if it holds the minimum, else the lowest one.
    always_comb begin
        any_part = 1'b0;
        all_full = 1'b1;
        sel      = '0;
        for (int i = 0; i < EFF_WAYS; i++) begin
            if (part[i]) begin
                any_part = 1'b1;
                sel      = WAY_W'(i);
                if (!head_full_reg[i]) begin
                    all_full = 1'b0;
                end
            end
        end
        min_key = head_key_reg[sel];
        for (int i = 0; i < EFF_WAYS; i++) begin
            if (part[i] && (head_key_reg[i] < min_key)) begin
                sel     = WAY_W'(i);
                min_key = head_key_reg[i];
            end
        end
    end

    // Participation once the selected head is emitted.
    assign sel_final  = head_final_reg[sel];
    assign part_after = part & ~(sel_final ? (EFF_WAYS'(1) << sel) : '0);
    assign left       = |part_after;

    // Status toward the controller.
    assign status.accept_ok  = in_range && part[in_way] && !head_full_reg[in_way];
    assign status.emit_ready = any_part && all_full
                               && (emit_cnt_reg < CNT_W'(MAX_RESULTS));
    assign status.out_free   = !m_valid_reg || m_tready;
    assign status.last_emit  = !(sel_final && left
                                 && (emit_cnt_reg < CNT_W'(MAX_RESULTS - 1)));

    // Control state: mask, slot flags, emission count, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_mask_reg <= '1;
            head_full_reg   <= '0;
            head_final_reg  <= '0;
            finished_reg    <= '0;
            emit_cnt_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr) begin
                active_mask_reg <= cfg_data;
            end
            if (cmd.take_in) begin
                emit_cnt_reg <= '0;
                if (status.accept_ok) begin
                    head_full_reg[in_way]  <= 1'b1;
                    head_final_reg[in_way] <= s_tlast;
                end
            end
            if (cmd.emit) begin
                head_full_reg[sel] <= 1'b0;
                emit_cnt_reg       <= emit_cnt_reg + CNT_W'(1);
                if (sel_final) begin
                    finished_reg[sel] <= 1'b1;
                end
            end
            if (cmd.emit || cmd.load_reject) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Head records and the stream of the item in flight.
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            in_stream_reg <= s_tuser;
            if (status.accept_ok) begin
                head_key_reg[in_way] <= in_key;
                head_pay_reg[in_way] <= in_pay[PAYLOAD_BITS-1:0];
            end
        end
    end

    // Output result fields.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_key_reg    <= min_key;
            out_pay_reg    <= PAYLOAD_W'(head_pay_reg[sel]);
            out_src_reg    <= STREAM_W'(sel);
            out_reject_reg <= 1'b0;
            out_done_reg   <= !left;
            out_last_reg   <= status.last_emit;
        end else if (cmd.load_reject) begin
            out_key_reg    <= '0;
            out_pay_reg    <= '0;
            out_src_reg    <= in_stream_reg;
            out_reject_reg <= 1'b1;
            out_done_reg   <= 1'b0;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_pay_reg, out_key_reg});
    assign m_tuser  = {out_done_reg, out_reject_reg, out_src_reg};
    assign m_tlast  = out_last_reg;

    // A finished stream never holds a head.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finished_reg & head_full_reg) == '0)
        else $error("finished stream still holds a head");

    // A result is only loaded when the output register is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit || cmd.load_reject) |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten while stalled");

    // The cascade never exceeds its bound.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("emission count past its bound");

endmodule

[rtl/k_way_record_merge.sv]
// k-way record merge, top level: joins the controller and the datapath.
// Depends on kwm_pkg, kwm_ctrl and kwm_datapath.
//
// Usage:
//   The s_ channel takes one record item per handshake: the stream index in
//   s_tuser, key and payload in s_tdata, the last-of-stream flag in s_tlast.
//   The m_ channel returns result items: key and payload in m_tdata, source
//   stream, reject and merge-done flags in m_tuser, and m_tlast on the last
//   result caused by one input item. An accepted record causes zero results
//   (it only filled a head slot), one reject result, or one or more emitted
//   records when every participating stream holds a head.
//   The cfg channel writes the 8-bit active stream mask; write it only while
//   the block is idle.
// Sequencing:
//   An item is accepted in the idle state and evaluated in the next cycle in
//   the select or reject state, which loads each result into the output
//   register once it is free; a new item is taken only back in idle. The
//   minimum select over all heads is combinational compare logic.
// Reset and stalls:
//   Reset empties all head slots, clears finished flags and sets the mask
//   to all ones. While m_tready is low, one result waits in the output
//   register; the block accepts a new item meanwhile, then holds further
//   results until the register frees.
`timescale 1ns / 1ps

module k_way_record_merge
    import kwm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write: active stream mask.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [MASK_W-1:0]    cfg_data,
    // Input records.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [31:0] record_key, [95:32] record_payload
    input  logic [S_TUSER_W-1:0] s_tuser,   // [2:0] stream_index
    input  logic                 s_tlast,   // last_of_stream
    // Merged results.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata,   // [31:0] out_key, [95:32] out_payload
    output logic [M_TUSER_W-1:0] m_tuser,   // [2:0] source_stream, [3] reject, [4] merge_done
    output logic                 m_tlast    // run_last
);

    kwm_cmd_t    cmd;
    kwm_status_t status;

    // The mask register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencing of accept, select and emit.
    kwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Head storage, selection and output register.
    kwm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_data (cfg_data),
        .cfg_wr   (cfg_valid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
